// ----- rtl/ppw_pkg.sv -----
// shared types and constants for the projective point warp
`timescale 1ns / 1ps
package ppw_pkg;

  localparam int CFG_W     = 32;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int PT_W      = 24;
  localparam int PROD_W    = CFG_W + PT_W;
  localparam int SUM_W     = 58;
  localparam int MAG_W     = SUM_W - 1;
  localparam int QUO_W     = 24;
  localparam int STAT_W    = 2;

  localparam logic [CFG_W-1:0] COEF_ONE = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX = 3'd0,
    REG_COEF_XY = 3'd1,
    REG_SHIFT_X = 3'd2,
    REG_COEF_YX = 3'd3,
    REG_COEF_YY = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_PERSP_X = 3'd6,
    REG_PERSP_Y = 3'd7
  } reg_idx_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_WZERO = 2'd2;

  typedef logic [NUM_REGS-1:0][CFG_W-1:0] coef_set_t;

  typedef struct packed {
    logic signed [PT_W-1:0] in_x;
    logic signed [PT_W-1:0] in_y;
  } in_item_t;

  typedef struct packed {
    logic signed [PT_W-1:0] out_x;
    logic signed [PT_W-1:0] out_y;
    logic [STAT_W-1:0]      status;
  } out_item_t;

  // one division lane: partial remainder, quotient so far, numerator bits still to feed
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [1:0]       feed;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic             wzero;
    logic [MAG_W-1:0] den;
    lane_t            lu;
    lane_t            lv;
  } stage_t;

endpackage

// ----- rtl/projective_point_warp.sv -----
// top level: config registers, front stages, divider cell chain, output stage
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+--------------------------
//  input   | start, busy, in_data                | taken when start && !busy
//  result  | out_strobe, out_data                | one cycle, no backpressure
//  config  | cfg_we, cfg_index, cfg_wdata        | written when cfg_we
//
// one item per clock; each item passes through, in order:
// four multiply/sum/magnitude stages, one cell per quotient bit (24), one output stage.
// busy is high only while rst_n is low; reset restores the identity mapping
// and empties the pipeline. the receiver cannot stall, so nothing ever backs up.
`timescale 1ns / 1ps
module projective_point_warp import ppw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_strobe,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int LAT = 4 + QUO_W + 1;

  localparam logic [CFG_W-1:0] COEF_ZERO = '0;
  // identity mapping: unit scale on both axes, everything else zero
  localparam coef_set_t COEF_RESET = {COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE,
                                      COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE};

  coef_set_t coef_r;
  logic      accept;

  logic   vld_c [QUO_W+1];
  stage_t stg_c [QUO_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  assign busy   = !rst_n;
  assign accept = start && !busy;

  ppw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (accept),
    .in_item   (in_data),
    .coef      (coef_r),
    .out_vld   (vld_c[0]),
    .out_stage (stg_c[0])
  );

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    ppw_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (vld_c[k]),
      .in_stage  (stg_c[k]),
      .out_vld   (vld_c[k+1]),
      .out_stage (stg_c[k+1])
    );
  end

  ppw_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (vld_c[QUO_W]),
    .in_stage   (stg_c[QUO_W]),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_strobe)
    else $error("item did not come out after the pipeline latency");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LAT))
    else $error("result without a matching item");

  a_wzero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == ST_WZERO) |-> (out_data.out_x == '0 && out_data.out_y == '0))
    else $error("zero w result carries nonzero coordinates");
`endif

endmodule

// ----- rtl/ppw_front.sv -----
// multiply, sum and magnitude stages ahead of the divider chain
`timescale 1ns / 1ps
module ppw_front import ppw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  in_item_t  in_item,
  input  coef_set_t coef,
  output logic      out_vld,
  output stage_t    out_stage
);

  localparam logic signed [SUM_W-1:0] ONE_Q38 = {{(SUM_W-39){1'b0}}, 1'b1, 38'b0};

  logic [3:0] vld_r;

  logic signed [PROD_W-1:0] p_xx_r, p_xy_r, p_yx_r, p_yy_r, p_wx_r, p_wy_r;
  logic signed [CFG_W-1:0]  sx_r, sy_r;
  logic signed [SUM_W-1:0]  u_r, v_r, w_r;
  logic [MAG_W-1:0]         mu_r, mv_r, mw_r;
  logic                     negu_r, negv_r, wz_r;
  stage_t                   stage_r;

  function automatic logic signed [SUM_W-1:0] ext_p(input logic signed [PROD_W-1:0] p);
    ext_p = {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_s(input logic signed [CFG_W-1:0] s);
    ext_s = {{(SUM_W-CFG_W-8){s[CFG_W-1]}}, s, 8'b0};
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [SUM_W-1:0] a);
    logic [SUM_W-1:0] t;
    t   = a[SUM_W-1] ? (~a + 1'b1) : a;
    mag = t[MAG_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    p_xx_r <= $signed(coef[REG_COEF_XX]) * in_item.in_x;
    p_xy_r <= $signed(coef[REG_COEF_XY]) * in_item.in_y;
    p_yx_r <= $signed(coef[REG_COEF_YX]) * in_item.in_x;
    p_yy_r <= $signed(coef[REG_COEF_YY]) * in_item.in_y;
    p_wx_r <= $signed(coef[REG_PERSP_X]) * in_item.in_x;
    p_wy_r <= $signed(coef[REG_PERSP_Y]) * in_item.in_y;
    sx_r   <= $signed(coef[REG_SHIFT_X]);
    sy_r   <= $signed(coef[REG_SHIFT_Y]);

    u_r <= ext_p(p_xx_r) + ext_p(p_xy_r) + ext_s(sx_r);
    v_r <= ext_p(p_yx_r) + ext_p(p_yy_r) + ext_s(sy_r);
    w_r <= ext_p(p_wx_r) + ext_p(p_wy_r) + ONE_Q38;

    mu_r   <= mag(u_r);
    mv_r   <= mag(v_r);
    mw_r   <= mag(w_r);
    negu_r <= u_r[SUM_W-1] ^ w_r[SUM_W-1];
    negv_r <= v_r[SUM_W-1] ^ w_r[SUM_W-1];
    wz_r   <= (w_r == '0);

    // quotient reaches 2^24 exactly when |num| >= 4 * |den|
    stage_r.wzero   <= wz_r;
    stage_r.den     <= mw_r;
    stage_r.lu.rem  <= {2'b00, mu_r[MAG_W-1:2]};
    stage_r.lu.quo  <= '0;
    stage_r.lu.feed <= mu_r[1:0];
    stage_r.lu.neg  <= negu_r;
    stage_r.lu.ovf  <= ({2'b00, mu_r} >= {mw_r, 2'b00});
    stage_r.lv.rem  <= {2'b00, mv_r[MAG_W-1:2]};
    stage_r.lv.quo  <= '0;
    stage_r.lv.feed <= mv_r[1:0];
    stage_r.lv.neg  <= negv_r;
    stage_r.lv.ovf  <= ({2'b00, mv_r} >= {mw_r, 2'b00});
  end

  assign out_vld   = vld_r[3];
  assign out_stage = stage_r;

endmodule

// ----- rtl/ppw_cell.sv -----
// one restoring division step for both coordinates
`timescale 1ns / 1ps
module ppw_cell import ppw_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_vld,
  input  stage_t in_stage,
  output logic   out_vld,
  output stage_t out_stage
);

  logic   vld_r;
  stage_t stage_r;

  function automatic lane_t step(input lane_t l, input logic [MAG_W-1:0] den);
    lane_t            n;
    logic [MAG_W:0]   t;
    logic [MAG_W:0]   d;
    n = l;
    t = {l.rem, l.feed[1]};
    d = {1'b0, den};
    if (t >= d) begin
      t = t - d;
      n.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      n.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    n.rem  = t[MAG_W-1:0];
    n.feed = {l.feed[0], 1'b0};
    step = n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    stage_r.wzero <= in_stage.wzero;
    stage_r.den   <= in_stage.den;
    stage_r.lu    <= step(in_stage.lu, in_stage.den);
    stage_r.lv    <= step(in_stage.lv, in_stage.den);
  end

  assign out_vld   = vld_r;
  assign out_stage = stage_r;

endmodule

// ----- rtl/ppw_out.sv -----
// rounding, saturation and status for the result item
`timescale 1ns / 1ps
module ppw_out import ppw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  stage_t    in_stage,
  output logic      out_strobe,
  output out_item_t out_data
);

  localparam logic [QUO_W:0] POS_MAX = {2'b00, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W:0] NEG_MAG = {2'b01, {(QUO_W-1){1'b0}}};

  logic       strobe_r;
  out_item_t  data_r;
  logic [PT_W:0] fu, fv;

  // returns {saturated, coordinate}
  function automatic logic [PT_W:0] finish(input lane_t l, input logic [MAG_W-1:0] den);
    logic [QUO_W:0] qr;
    logic [PT_W-1:0] val;
    logic            sat;
    qr = {1'b0, l.quo} + {{QUO_W{1'b0}}, ({l.rem, 1'b0} >= {1'b0, den})};
    if (!l.neg) begin
      sat = l.ovf || (qr > POS_MAX);
      val = sat ? POS_MAX[PT_W-1:0] : qr[PT_W-1:0];
    end else begin
      sat = l.ovf || (qr > NEG_MAG);
      val = sat ? NEG_MAG[PT_W-1:0] : (~qr[PT_W-1:0] + 1'b1);
    end
    finish = {sat, val};
  endfunction

  assign fu = finish(in_stage.lu, in_stage.den);
  assign fv = finish(in_stage.lv, in_stage.den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stage.wzero) begin
      data_r.out_x  <= '0;
      data_r.out_y  <= '0;
      data_r.status <= ST_WZERO;
    end else begin
      data_r.out_x  <= fu[PT_W-1:0];
      data_r.out_y  <= fv[PT_W-1:0];
      data_r.status <= (fu[PT_W] || fv[PT_W]) ? ST_SAT : ST_OK;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

endmodule

// ----- sim/tb_projective_point_warp.sv -----
// testbench for the projective point warp: directed and random points across coefficient sets
`timescale 1ns / 1ps
module tb_projective_point_warp;
  import ppw_pkg::*;

  // expected results of the point warp, predicted from the coefficient registers
  class warp_scoreboard;
    logic signed [CFG_W-1:0] coef [NUM_REGS];
    out_item_t               expected_q [$];
    int                      errors;

    function new();
      errors = 0;
      foreach (coef[i]) coef[i] = '0;
      coef[REG_COEF_XX] = COEF_ONE;
      coef[REG_COEF_YY] = COEF_ONE;
    endfunction

    // rounded (n * 2^22) / d, saturated to 24 bits; msb of the return is the saturation flag
    function logic [PT_W:0] quotient(logic signed [63:0] n, logic signed [63:0] d);
      logic [127:0] un, ud, q, r;
      logic         neg;
      neg = (n < 0) != (d < 0);
      un  = {64'd0, (n < 0) ? -n : n} << 22;
      ud  = {64'd0, (d < 0) ? -d : d};
      q   = un / ud;
      r   = un % ud;
      if (r >= ud - r) q = q + 1;
      if (!neg) begin
        if (q > 128'd8388607) return {1'b1, 24'h7fffff};
        return {1'b0, q[PT_W-1:0]};
      end
      if (q > 128'd8388608) return {1'b1, 24'h800000};
      return {1'b0, -q[PT_W-1:0]};
    endfunction

    function void note_item(in_item_t it);
      logic signed [63:0] x, y, u, v, w;
      logic [PT_W:0]      qx, qy;
      out_item_t          r;
      x = it.in_x;
      y = it.in_y;
      u = coef[REG_COEF_XX] * x + coef[REG_COEF_XY] * y + coef[REG_SHIFT_X] * 64'sd256;
      v = coef[REG_COEF_YX] * x + coef[REG_COEF_YY] * y + coef[REG_SHIFT_Y] * 64'sd256;
      w = coef[REG_PERSP_X] * x + coef[REG_PERSP_Y] * y + (64'sd1 <<< 38);
      if (w == 0) begin
        r.out_x  = '0;
        r.out_y  = '0;
        r.status = ST_WZERO;
      end else begin
        qx = quotient(u, w);
        qy = quotient(v, w);
        r.out_x  = qx[PT_W-1:0];
        r.out_y  = qy[PT_W-1:0];
        r.status = (qx[PT_W] || qy[PT_W]) ? ST_SAT : ST_OK;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h status=%0d",
                 $time, got.out_x, got.out_y, got.status);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.out_x !== exp_r.out_x) begin
        $display("%0t: out_x expected %h actual %h", $time, exp_r.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== exp_r.out_y) begin
        $display("%0t: out_y expected %h actual %h", $time, exp_r.out_y, got.out_y);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_strobe;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  warp_scoreboard sb = new();

  projective_point_warp u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL projective_point_warp");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_item(in_data);
    if (rst_n && out_strobe) sb.check_result(out_data);
  end

  task send_point(logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y);
    start   <= 1'b1;
    in_data <= '{in_x: x, in_y: y};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // registers change only with the pipeline empty
  task load_coefs(logic [CFG_W-1:0] c [NUM_REGS]);
    reg_idx_t idx;
    wait_drained();
    idx = idx.first();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= c[i];
      @(posedge clk);
      sb.coef[i] = c[i];
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  function logic [PT_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return PT_W'($urandom);
      1: return PT_W'($urandom_range(0, 4095) - 2048);
      2: return PT_W'($urandom_range(0, 262143) - 131072);
      default: return $urandom_range(0, 1) ? PT_W'(24'h7fffff - $urandom_range(0, 3))
                                            : PT_W'(24'h800000 + $urandom_range(0, 3));
    endcase
  endfunction

  task random_burst_run(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      for (int b = $urandom_range(1, 12); b > 0 && sent < count; b--) begin
        send_point(rand_coord(), rand_coord());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
    end
  endtask

  logic [CFG_W-1:0] cset [NUM_REGS];

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity after reset: extremes and zero
    send_point(24'h000000, 24'h000000);
    send_point(24'h7fffff, 24'h800000);
    send_point(24'h800000, 24'h7fffff);
    send_point(24'hffffff, 24'h000001);
    pause(3);
    send_point(24'h000100, 24'hffff00);

    // scale by 2 so extremes saturate both ways
    cset = '{32'h0002_0000, 0, 32'h0000_8000, 0, 32'h0002_0000, 32'hffff_8000, 0, 0};
    load_coefs(cset);
    send_point(24'h7fffff, 24'h800000);
    send_point(24'h400000, 24'h3fffff);
    send_point(24'h000001, 24'hffffff);

    // w goes to zero at x = 1.0 exactly
    cset = '{COEF_ONE, 0, 0, 0, COEF_ONE, 0, 32'hc000_0000, 0};
    load_coefs(cset);
    send_point(24'h000100, 24'h001234);
    send_point(24'h000080, 24'h000100);
    send_point(24'h000200, 24'hfff000);
    send_point(24'h0000ff, 24'h000000);

    // all registers at their maximum, then at their minimum
    cset = '{default: 32'h7fff_ffff};
    load_coefs(cset);
    send_point(24'h7fffff, 24'h7fffff);
    send_point(24'h800000, 24'h800000);
    send_point(24'h000000, 24'h000000);
    send_point(24'hfffc00, 24'h000001);
    cset = '{default: 32'h8000_0000};
    load_coefs(cset);
    send_point(24'h7fffff, 24'h800000);
    send_point(24'h800000, 24'h800000);
    send_point(24'h000000, 24'h000000);
    send_point(24'h000001, 24'h000000);

    // random phases with random coefficients
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        case ($urandom_range(0, 3))
          0: cset[i] = $urandom;
          1: cset[i] = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
          default: cset[i] = (i >= REG_PERSP_X) ? $urandom_range(0, 2048) - 1024
                                                : $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        endcase
      end
      load_coefs(cset);
      random_burst_run(120);
    end

    // back to identity, then drain and wait out the pipeline
    cset = '{COEF_ONE, 0, 0, 0, COEF_ONE, 0, 0, 0};
    load_coefs(cset);
    random_burst_run(30);
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS projective_point_warp");
    end else begin
      $display("FAIL projective_point_warp");
    end
    $finish;
  end

endmodule
